>>> src/apn_pkg.sv
// Shared types, codes and constants of the absolute path normalizer.
package apn_pkg;

  // Default sizes of the output store and of the restore stack
  localparam int OUT_BYTES_DEF = 256;
  localparam int MAX_DEPTH_DEF = 256;

  // Output limit register
  localparam int            LIMIT_W   = 9;
  localparam logic [8:0]    LIMIT_RST = 9'd256;

  // Characters the parser cares about
  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_DOT   = 8'h2E;

  typedef enum logic {
    OP_FEED = 1'b0,
    OP_READ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_TOO_LONG  = 2'd2
  } status_e;

  // Input beat
  typedef struct packed {
    logic       opcode;
    logic [7:0] path_byte;
    logic       last_byte;
    logic [7:0] read_index;
  } apn_in_t;

  // Output beat
  typedef struct packed {
    logic       done_res;
    logic [1:0] status;
    logic [7:0] norm_length;
    logic [7:0] read_data;
  } apn_out_t;

  // Result of one item as it leaves the control stage
  typedef struct packed {
    logic       done_res;
    logic [1:0] status;
    logic [7:0] norm_length;
    logic       rd_ok;     // read_data comes from the output store
    logic       len_stk;   // length comes from the restore stack read
  } apn_res_t;

endpackage

>>> src/apn_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
module apn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/apn_ctrl.sv
// Parser state, limit register and read-modify-write control of both memories.
module apn_ctrl #(
  parameter int OUT_BYTES = apn_pkg::OUT_BYTES_DEF,
  parameter int MAX_DEPTH = apn_pkg::MAX_DEPTH_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [apn_pkg::LIMIT_W-1:0]       cfg_wdata_i,
  input  logic                              acc_i,
  input  apn_pkg::apn_in_t                  in_i,
  input  logic [$clog2(OUT_BYTES)-1:0]      stk_rdata_i,
  output logic                              ob_we_o,
  output logic [$clog2(OUT_BYTES)-1:0]      ob_waddr_o,
  output logic [7:0]                        ob_wdata_o,
  output logic                              ob_re_o,
  output logic [$clog2(OUT_BYTES)-1:0]      ob_raddr_o,
  output logic                              stk_we_o,
  output logic [$clog2(MAX_DEPTH)-1:0]      stk_waddr_o,
  output logic [$clog2(OUT_BYTES)-1:0]      stk_wdata_o,
  output logic                              stk_re_o,
  output logic [$clog2(MAX_DEPTH)-1:0]      stk_raddr_o,
  output apn_pkg::apn_res_t                 res_o
);

  localparam int AW  = $clog2(OUT_BYTES);
  localparam int SW  = $clog2(MAX_DEPTH);
  localparam int DCW = $clog2(MAX_DEPTH + 1);
  localparam int CW  = ((AW > apn_pkg::LIMIT_W) ? AW : apn_pkg::LIMIT_W) + 2;

  logic [apn_pkg::LIMIT_W-1:0] out_limit_q;
  logic [AW-1:0]               wp_q, wp_d, wp_cur;
  logic [DCW-1:0]              depth_q, depth_d;
  logic [1:0]                  pend_q, pend_d;
  logic [1:0]                  seglen_q, seglen_d;   // saturates at 3
  apn_pkg::status_e            err_q, err_d;
  logic                        started_q, started_d;
  logic                        done_q, done_d;
  logic                        pop_q, pop_d;
  logic [CW-1:0]               lim_c;

  // Limit register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_limit_q <= apn_pkg::LIMIT_RST;
    end else if (cfg_we_i) begin
      out_limit_q <= cfg_wdata_i;
    end
  end

  assign lim_c = (CW'(out_limit_q) > CW'(OUT_BYTES)) ? CW'(OUT_BYTES) : CW'(out_limit_q);

  // Write position restored by a pop is forwarded straight from the stack read
  assign wp_cur = pop_q ? stk_rdata_i : wp_q;

  // Per-item update
  always_comb begin
    logic [AW-1:0]    v_wp;
    logic [DCW-1:0]   v_depth;
    logic [1:0]       v_pend;
    logic [1:0]       v_seglen;
    apn_pkg::status_e v_err;
    logic [7:0]       b;
    logic             ends;
    logic             is_sep;
    logic             s;
    logic             pop;
    logic             end_now;
    logic [CW-1:0]    pos;
    logic [CW-1:0]    nput;
    logic [CW-1:0]    room;
    logic [CW-1:0]    wp_x;

    wp_d      = wp_cur;
    depth_d   = depth_q;
    pend_d    = pend_q;
    seglen_d  = seglen_q;
    err_d     = err_q;
    started_d = started_q;
    done_d    = done_q;
    pop_d     = 1'b0;

    ob_we_o     = 1'b0;
    ob_waddr_o  = '0;
    ob_wdata_o  = '0;
    ob_re_o     = 1'b0;
    ob_raddr_o  = AW'(in_i.read_index);
    stk_we_o    = 1'b0;
    stk_waddr_o = '0;
    stk_wdata_o = '0;
    stk_re_o    = 1'b0;
    stk_raddr_o = '0;
    res_o       = '0;

    b      = in_i.path_byte;
    ends   = (b == apn_pkg::CHAR_NUL) || in_i.last_byte;
    is_sep = (b == apn_pkg::CHAR_SLASH) || (b == apn_pkg::CHAR_NUL);

    // A feed after the end of a path starts over
    if (done_q) begin
      v_wp     = AW'(1);
      v_depth  = '0;
      v_pend   = '0;
      v_seglen = '0;
      v_err    = apn_pkg::ST_OK;
    end else begin
      v_wp     = wp_cur;
      v_depth  = depth_q;
      v_pend   = pend_q;
      v_seglen = seglen_q;
      v_err    = err_q;
    end
    s       = (v_depth != '0);
    pop     = 1'b0;
    end_now = 1'b0;
    pos     = '0;
    nput    = '0;
    room    = '0;
    wp_x    = CW'(v_wp);

    if (acc_i && (in_i.opcode == apn_pkg::OP_FEED)) begin
      if (v_err == apn_pkg::ST_OK) begin
        if (done_q || !started_q) begin
          // first byte: root slash goes to entry 0
          ob_we_o    = 1'b1;
          ob_waddr_o = '0;
          ob_wdata_o = apn_pkg::CHAR_SLASH;
          if ((b != apn_pkg::CHAR_SLASH) || (lim_c < CW'(2))) begin
            v_err = apn_pkg::ST_BAD_START;
          end
        end else if (is_sep) begin
          // keep a separator ready at the write position for the next segment
          ob_we_o    = 1'b1;
          ob_waddr_o = v_wp;
          ob_wdata_o = apn_pkg::CHAR_SLASH;
        end else if ((v_seglen == v_pend) && (b == apn_pkg::CHAR_DOT) && (v_pend != 2'd2)) begin
          // held-back dot, stored beyond the committed length
          pos        = wp_x + CW'(s) + CW'(v_pend);
          ob_we_o    = (pos < CW'(OUT_BYTES));
          ob_waddr_o = AW'(pos);
          ob_wdata_o = apn_pkg::CHAR_DOT;
          v_pend     = v_pend + 2'd1;
          v_seglen   = v_seglen + 2'd1;
        end else if (v_seglen == v_pend) begin
          // first name byte: push restore position, commit slash and dots
          if (v_depth >= DCW'(MAX_DEPTH)) begin
            v_err = apn_pkg::ST_TOO_LONG;
          end else begin
            stk_we_o    = 1'b1;
            stk_waddr_o = v_depth[SW-1:0];
            stk_wdata_o = v_wp;
            pos         = wp_x + CW'(s) + CW'(v_pend);
            ob_we_o     = (pos < CW'(OUT_BYTES));
            ob_waddr_o  = AW'(pos);
            ob_wdata_o  = b;
            nput        = CW'(s) + CW'(v_pend) + CW'(1);
            room        = (lim_c > wp_x + CW'(1)) ? (lim_c - wp_x - CW'(1)) : '0;
            if (room >= nput) begin
              v_wp     = AW'(wp_x + nput);
              v_depth  = v_depth + DCW'(1);
              v_seglen = (v_seglen == 2'd3) ? 2'd3 : (v_seglen + 2'd1);
            end else begin
              v_err = apn_pkg::ST_TOO_LONG;
              v_wp  = AW'(wp_x + room);
            end
            v_pend = '0;
          end
        end else begin
          // ordinary name byte
          if (wp_x + CW'(1) >= lim_c) begin
            v_err = apn_pkg::ST_TOO_LONG;
          end else begin
            ob_we_o    = 1'b1;
            ob_waddr_o = v_wp;
            ob_wdata_o = b;
            v_wp       = v_wp + AW'(1);
            v_seglen   = (v_seglen == 2'd3) ? 2'd3 : (v_seglen + 2'd1);
          end
        end

        // segment end: ".." pops one level unless at the root
        end_now = (!done_q && started_q && is_sep) || (ends && (v_err == apn_pkg::ST_OK));
        if (end_now) begin
          if ((v_seglen != '0) && (v_pend == 2'd2) && (v_depth != '0)) begin
            pop         = 1'b1;
            v_depth     = v_depth - DCW'(1);
            stk_re_o    = 1'b1;
            stk_raddr_o = v_depth[SW-1:0];
          end
          v_seglen = '0;
          v_pend   = '0;
        end
      end

      wp_d      = v_wp;
      depth_d   = v_depth;
      pend_d    = v_pend;
      seglen_d  = v_seglen;
      err_d     = v_err;
      started_d = 1'b1;
      done_d    = ends;
      pop_d     = pop;

      res_o.done_res    = ends;
      res_o.status      = v_err;
      res_o.norm_length = (v_err == apn_pkg::ST_BAD_START) ? 8'd0 : 8'(v_wp);
      res_o.len_stk     = pop;
      res_o.rd_ok       = 1'b0;
    end else if (acc_i) begin
      // read beat: state untouched
      ob_re_o           = 1'b1;
      res_o.done_res    = done_q;
      res_o.status      = err_q;
      res_o.norm_length = (err_q == apn_pkg::ST_BAD_START) ? 8'd0 : 8'(wp_cur);
      res_o.len_stk     = 1'b0;
      res_o.rd_ok       = (err_q != apn_pkg::ST_BAD_START)
                          && (CW'(in_i.read_index) < CW'(wp_cur))
                          && (CW'(in_i.read_index) < CW'(OUT_BYTES));
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q      <= AW'(1);
      depth_q   <= '0;
      pend_q    <= '0;
      seglen_q  <= '0;
      err_q     <= apn_pkg::ST_OK;
      started_q <= 1'b0;
      done_q    <= 1'b0;
      pop_q     <= 1'b0;
    end else begin
      wp_q      <= wp_d;
      depth_q   <= depth_d;
      pend_q    <= pend_d;
      seglen_q  <= seglen_d;
      err_q     <= err_d;
      started_q <= started_d;
      done_q    <= done_d;
      pop_q     <= pop_d;
    end
  end

endmodule

>>> src/apn_resq.sv
// Result queue: waits for memory read data, then holds the output beat.
module apn_resq #(
  parameter int OUT_BYTES = apn_pkg::OUT_BYTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         acc_i,
  input  apn_pkg::apn_res_t            res_i,
  input  logic [7:0]                   ob_rdata_i,
  input  logic [$clog2(OUT_BYTES)-1:0] stk_rdata_i,
  output logic                         in_stall_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output apn_pkg::apn_out_t            out_data_o
);

  logic              s1v_q, s1v_d;
  apn_pkg::apn_res_t s1_q;
  logic              ov_q, ov_d;
  apn_pkg::apn_out_t od_q, od_d;
  logic              adv;

  // Beat in the memory stage moves on when the output slot frees
  assign adv        = s1v_q && (!ov_q || !out_stall_i);
  assign in_stall_o = s1v_q && !adv;

  always_comb begin
    s1v_d = acc_i ? 1'b1 : (adv ? 1'b0 : s1v_q);
    ov_d  = adv ? 1'b1 : (out_stall_i ? ov_q : 1'b0);
    od_d  = od_q;
    if (adv) begin
      od_d.done_res    = s1_q.done_res;
      od_d.status      = s1_q.status;
      od_d.norm_length = s1_q.len_stk ? 8'(stk_rdata_i) : s1_q.norm_length;
      od_d.read_data   = s1_q.rd_ok ? ob_rdata_i : 8'd0;
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1v_q <= 1'b0;
      ov_q  <= 1'b0;
    end else begin
      s1v_q <= s1v_d;
      ov_q  <= ov_d;
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= res_i;
    end
    od_q <= od_d;
  end

  assign out_valid_o = ov_q;
  assign out_data_o  = od_q;

endmodule

>>> src/abs_path_normalizer.sv
// Top level of the absolute path normalizer.
// One beat is taken per cycle while the input is not stalled, feed or read alike; its
// result passes through the registered read of the output store or restore stack RAM
// and then the output register. Each feed does a single read-modify-write of the parser
// registers with at most one output store write and one restore stack access; a ".."
// pop forwards the restored write position from the stack read port to the next beat,
// so a pop never holds up the next beat. The result side holds up to two beats; input
// stalls only while both are waiting on a stalled output. Neither memory is cleared after
// reset, so the block is ready at once; a read of an output entry that no path has
// written returns unspecified data.
module abs_path_normalizer #(
  parameter int OUT_BYTES = apn_pkg::OUT_BYTES_DEF,
  parameter int MAX_DEPTH = apn_pkg::MAX_DEPTH_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [apn_pkg::LIMIT_W-1:0] cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  apn_pkg::apn_in_t            in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output apn_pkg::apn_out_t           out_data_o
);

  localparam int AW = $clog2(OUT_BYTES);
  localparam int SW = $clog2(MAX_DEPTH);

  logic              acc;
  logic              ob_we, ob_re;
  logic [AW-1:0]     ob_waddr, ob_raddr;
  logic [7:0]        ob_wdata, ob_rdata;
  logic              stk_we, stk_re;
  logic [SW-1:0]     stk_waddr, stk_raddr;
  logic [AW-1:0]     stk_wdata, stk_rdata;
  apn_pkg::apn_res_t res;

  assign acc = in_valid_i && !in_stall_o;

  apn_ctrl #(
    .OUT_BYTES (OUT_BYTES),
    .MAX_DEPTH (MAX_DEPTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .acc_i       (acc),
    .in_i        (in_data_i),
    .stk_rdata_i (stk_rdata),
    .ob_we_o     (ob_we),
    .ob_waddr_o  (ob_waddr),
    .ob_wdata_o  (ob_wdata),
    .ob_re_o     (ob_re),
    .ob_raddr_o  (ob_raddr),
    .stk_we_o    (stk_we),
    .stk_waddr_o (stk_waddr),
    .stk_wdata_o (stk_wdata),
    .stk_re_o    (stk_re),
    .stk_raddr_o (stk_raddr),
    .res_o       (res)
  );

  // Normalized path bytes
  apn_ram #(
    .WIDTH (8),
    .DEPTH (OUT_BYTES)
  ) u_out_ram (
    .clk_i   (clk_i),
    .we_i    (ob_we),
    .waddr_i (ob_waddr),
    .wdata_i (ob_wdata),
    .re_i    (ob_re),
    .raddr_i (ob_raddr),
    .rdata_o (ob_rdata)
  );

  // Write positions to restore on ".."
  apn_ram #(
    .WIDTH (AW),
    .DEPTH (MAX_DEPTH)
  ) u_stk_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  apn_resq #(
    .OUT_BYTES (OUT_BYTES)
  ) u_resq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .acc_i       (acc),
    .res_i       (res),
    .ob_rdata_i  (ob_rdata),
    .stk_rdata_i (stk_rdata),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> src/apn_chk.sv
// Port-level checks of the path normalizer, bound to the top level.
module apn_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_stall_i,
  input logic              out_valid_i,
  input logic              out_stall_i,
  input apn_pkg::apn_out_t out_data_i
);

  // Stalled output beat stays
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> out_valid_i)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_stall_i |=> $stable(out_data_i))
    else $error("output beat changed while stalled");

  // Every accepted beat is followed by a valid output beat
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_i |-> ##2 out_valid_i)
    else $error("accepted beat produced no output");

  // A bad start reports zero length
  a_bad_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.status == apn_pkg::ST_BAD_START)
    |-> out_data_i.norm_length == 8'd0)
    else $error("nonzero length with bad start");

  // Nothing can be read from an empty result
  a_empty_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_data_i.norm_length == 8'd0) |-> out_data_i.read_data == 8'd0)
    else $error("read data beyond length");

endmodule

bind abs_path_normalizer apn_chk u_apn_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_i  (in_stall_o),
  .out_valid_i (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_i  (out_data_o)
);

>>> sim/tb.sv
// Self-checking testbench for the absolute path normalizer.
module tb;
  import apn_pkg::*;

  localparam int ITEMS      = 1650;  // beats to send before wrapping up
  localparam int MAX_GAP    = 11;    // longest idle run on either side
  localparam int QUIET_MAX  = 500;   // cycles without any beat before giving up

  typedef enum logic [1:0] {
    ROW_FEED,
    ROW_READ,
    ROW_LIMIT
  } row_kind_e;

  // One line of the directed table
  typedef struct {
    row_kind_e  kind;
    logic [8:0] val;    // path byte, read index or limit
    logic       last;
    logic       typed;  // want holds a hand-written result
    apn_out_t   want;
  } dir_row_t;

  logic               clk_i       = 1'b0;
  logic               rst_ni      = 1'b0;
  logic               cfg_we_i    = 1'b0;
  logic [LIMIT_W-1:0] cfg_wdata_i = '0;
  logic               in_valid_i  = 1'b0;
  logic               in_stall_o;
  apn_in_t            in_data_i   = '0;
  logic               out_valid_o;
  logic               out_stall_i = 1'b0;
  apn_out_t           out_data_o;

  // Shadow of the normalizer state
  logic [7:0] norm_mem [OUT_BYTES_DEF];
  logic [8:0] mark_mem [MAX_DEPTH_DEF];  // write position saved when a segment opens
  logic [8:0] depth;
  logic [8:0] wr_pos;
  logic [8:0] seg_bytes;
  logic [8:0] byte_cnt;
  logic [1:0] dots_held;
  status_e    err;
  logic       path_ended;
  logic [8:0] limit_reg;
  logic       root_valid;  // entry 0 has been written by a path restart

  apn_out_t   pending_res[$];
  logic [7:0] path_q[$];

  logic in_idle  = 1'b0;
  logic out_idle = 1'b0;
  int   hold     = 0;
  int   quiet    = 0;
  int   errors   = 0;
  int   n_items  = 0;
  int   n_results = 0;
  int   n_paths  = 0;
  int   n_cfg    = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  abs_path_normalizer i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // ---------------------------------------------------------------------------
  // Normalizer shadow
  // ---------------------------------------------------------------------------

  function automatic int eff_limit();
    return (limit_reg > OUT_BYTES_DEF) ? OUT_BYTES_DEF : int'(limit_reg);
  endfunction

  function automatic void restart_path();
    norm_mem[0] = CHAR_SLASH;
    depth       = '0;
    wr_pos      = 9'd1;
    dots_held   = '0;
    seg_bytes   = '0;
    err         = ST_OK;
    byte_cnt    = '0;
    path_ended  = 1'b0;
  endfunction

  function automatic void reset_shadow();
    foreach (norm_mem[i]) norm_mem[i] = '0;
    foreach (mark_mem[i]) mark_mem[i] = '0;
    limit_reg  = LIMIT_RST;
    root_valid = 1'b0;
    restart_path();
  endfunction

  // Append one output byte; the last slot is kept for the terminator
  function automatic logic append_byte(input logic [7:0] b);
    if (int'(wr_pos) + 1 >= eff_limit() || int'(wr_pos) >= OUT_BYTES_DEF) begin
      err = ST_TOO_LONG;
      return 1'b0;
    end
    norm_mem[wr_pos] = b;
    wr_pos++;
    return 1'b1;
  endfunction

  // A segment that was exactly ".." drops the previous one, root stays root
  function automatic void close_segment();
    if (seg_bytes != 0 && dots_held == 2 && depth != 0) begin
      depth--;
      if (depth < MAX_DEPTH_DEF) wr_pos = mark_mem[depth];
    end
    seg_bytes = '0;
    dots_held = '0;
  endfunction

  function automatic void feed_byte(input logic [7:0] b, input logic last);
    logic ends;
    logic ok;
    int   i;
    if (path_ended) begin
      restart_path();
      root_valid = 1'b1;
    end
    ends = (b == CHAR_NUL) || last;
    if (err == ST_OK) begin
      if (byte_cnt == 0) begin
        if (b != CHAR_SLASH || eff_limit() < 2) err = ST_BAD_START;
      end else if (b == CHAR_SLASH || b == CHAR_NUL) begin
        close_segment();
      end else if (seg_bytes == dots_held && b == CHAR_DOT && dots_held < 2) begin
        // one or two leading dots wait until the segment shows what it is
        dots_held++;
        seg_bytes++;
      end else begin
        // first byte that is not a held dot opens the segment
        if (seg_bytes == dots_held) begin
          if (depth >= MAX_DEPTH_DEF) begin
            err = ST_TOO_LONG;
          end else begin
            mark_mem[depth] = wr_pos;
            ok = 1'b1;
            if (depth != 0) ok = append_byte(CHAR_SLASH);
            for (i = 0; i < dots_held && ok; i++) ok = append_byte(CHAR_DOT);
            if (ok) begin
              depth++;
              dots_held = '0;
            end
          end
        end
        if (err == ST_OK) begin
          void'(append_byte(b));
          seg_bytes++;
        end
      end
      if (ends && err == ST_OK) close_segment();
    end
    if (byte_cnt < 511) byte_cnt++;
    if (ends) path_ended = 1'b1;
  endfunction

  function automatic apn_out_t predict_beat(input apn_in_t beat);
    apn_out_t   res;
    logic [8:0] len;
    if (beat.opcode == OP_FEED) feed_byte(beat.path_byte, beat.last_byte);
    len             = (err == ST_BAD_START) ? 9'd0 : wr_pos;
    res.done_res    = path_ended;
    res.status      = err;
    res.norm_length = len[7:0];
    res.read_data   = (beat.opcode == OP_READ && beat.read_index < len) ?
                      norm_mem[beat.read_index] : 8'h00;
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Present one beat, hold it until taken, then log what it should produce
  task automatic send_beat(input apn_in_t beat, input logic typed = 1'b0,
                           input apn_out_t want = '0);
    int       gap;
    apn_out_t res;
    gap = in_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= beat;
    do @(posedge clk_i); while (in_stall_o);
    res = predict_beat(beat);
    pending_res.push_back(typed ? want : res);
    n_items++;
  endtask

  // Drop valid and let every outstanding result come back
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_res.size() != 0);
  endtask

  task automatic set_limit(input logic [8:0] v);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i  <= 1'b0;
    limit_reg = v;
    n_cfg++;
  endtask

  // Random segment name, now and then a long one
  function automatic void add_name();
    int         n;
    logic [7:0] b;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
    repeat (n) begin
      if ($urandom_range(0, 3) != 0) begin
        b = 8'($urandom_range(8'h61, 8'h7a));
      end else begin
        b = 8'($urandom_range(1, 255));
        if (b == CHAR_SLASH) b = 8'h5f;
      end
      path_q.push_back(b);
    end
  endfunction

  // One path, mostly well formed, with reads mixed in
  task automatic random_path();
    apn_in_t beat;
    apn_in_t rd;
    int      nseg;
    int      ending;
    int      i;
    path_q.delete();
    if ($urandom_range(0, 9) == 0) begin
      // raw noise: may be relative, may hold a terminator anywhere
      repeat ($urandom_range(1, 16)) path_q.push_back(8'($urandom));
    end else begin
      path_q.push_back(CHAR_SLASH);
      nseg = $urandom_range(0, 12);
      for (i = 0; i < nseg; i++) begin
        if (i != 0) path_q.push_back(CHAR_SLASH);
        case ($urandom_range(0, 11))
          0: path_q.push_back(CHAR_DOT);
          1, 2: begin
            path_q.push_back(CHAR_DOT);
            path_q.push_back(CHAR_DOT);
          end
          3: repeat ($urandom_range(3, 5)) path_q.push_back(CHAR_DOT);
          4: path_q.push_back(CHAR_SLASH);
          5: begin
            repeat ($urandom_range(1, 2)) path_q.push_back(CHAR_DOT);
            add_name();
          end
          default: add_name();
        endcase
      end
      if ($urandom_range(0, 4) == 0) path_q.push_back(CHAR_SLASH);
    end
    // 0-1 terminator, 2 terminator with last flag, 3-6 last flag, 7 left open
    ending = $urandom_range(0, 7);
    if (ending <= 2) path_q.push_back(CHAR_NUL);
    foreach (path_q[k]) begin
      if ($urandom_range(0, 4) == 0) begin
        rd.opcode    = OP_READ;
        rd.path_byte = 8'($urandom);
        rd.last_byte = 1'($urandom);
        if ($urandom_range(0, 2) == 0) rd.read_index = 8'($urandom);
        else rd.read_index = 8'($urandom_range(0, int'(wr_pos)));
        if (rd.read_index == 0 && !root_valid) rd.read_index = 8'd1;
        send_beat(rd);
      end
      beat.opcode     = OP_FEED;
      beat.path_byte  = path_q[k];
      beat.last_byte  = (k == path_q.size() - 1 && ending >= 2 && ending <= 6) ||
                        ($urandom_range(0, 39) == 0);
      beat.read_index = 8'($urandom);
      send_beat(beat);
    end
    n_paths++;
  endtask

  function automatic dir_row_t row(input row_kind_e kind, input logic [8:0] val,
                                   input logic last = 1'b0, input logic typed = 1'b0,
                                   input apn_out_t want = '0);
    dir_row_t r;
    r.kind  = kind;
    r.val   = val;
    r.last  = last;
    r.typed = typed;
    r.want  = want;
    return r;
  endfunction

  initial begin : stimulus
    dir_row_t   rows[$];
    apn_in_t    beat;
    logic [8:0] lim;

    reset_shadow();
    // "//./.../.." ended by NUL: dot dropped, "..." kept, then popped
    rows.push_back(row(ROW_FEED, CHAR_SLASH));
    rows.push_back(row(ROW_FEED, CHAR_SLASH));
    rows.push_back(row(ROW_FEED, CHAR_DOT));
    rows.push_back(row(ROW_FEED, CHAR_SLASH));
    rows.push_back(row(ROW_FEED, CHAR_DOT));
    rows.push_back(row(ROW_FEED, CHAR_DOT));
    rows.push_back(row(ROW_FEED, CHAR_DOT));
    rows.push_back(row(ROW_FEED, CHAR_SLASH));
    rows.push_back(row(ROW_FEED, CHAR_DOT));
    rows.push_back(row(ROW_FEED, CHAR_DOT));
    rows.push_back(row(ROW_FEED, CHAR_NUL, 1'b0, 1'b1, {1'b1, ST_OK, 8'd1, 8'h00}));
    // new path "/../\xff": ".." at the root stays there, last flag ends it
    rows.push_back(row(ROW_FEED, CHAR_SLASH));
    rows.push_back(row(ROW_FEED, CHAR_DOT));
    rows.push_back(row(ROW_FEED, CHAR_DOT));
    rows.push_back(row(ROW_FEED, CHAR_SLASH));
    rows.push_back(row(ROW_FEED, 9'h0ff, 1'b1, 1'b1, {1'b1, ST_OK, 8'd2, 8'h00}));
    rows.push_back(row(ROW_READ, 9'd0, 1'b0, 1'b1, {1'b1, ST_OK, 8'd2, CHAR_SLASH}));
    rows.push_back(row(ROW_READ, 9'd1, 1'b0, 1'b1, {1'b1, ST_OK, 8'd2, 8'hff}));
    rows.push_back(row(ROW_READ, 9'd255, 1'b0, 1'b1, {1'b1, ST_OK, 8'd2, 8'h00}));
    // relative path, the rest is ignored until the terminator
    rows.push_back(row(ROW_FEED, 9'h061, 1'b0, 1'b1, {1'b0, ST_BAD_START, 8'd0, 8'h00}));
    rows.push_back(row(ROW_FEED, CHAR_NUL, 1'b0, 1'b1, {1'b1, ST_BAD_START, 8'd0, 8'h00}));
    // NUL as the very first byte
    rows.push_back(row(ROW_FEED, CHAR_NUL, 1'b1, 1'b1, {1'b1, ST_BAD_START, 8'd0, 8'h00}));
    // limit below two
    rows.push_back(row(ROW_LIMIT, 9'd1));
    rows.push_back(row(ROW_FEED, CHAR_SLASH, 1'b1, 1'b1, {1'b1, ST_BAD_START, 8'd0, 8'h00}));
    // limit shrinks mid path and the next byte overflows
    rows.push_back(row(ROW_LIMIT, 9'd3));
    rows.push_back(row(ROW_FEED, CHAR_SLASH, 1'b0, 1'b1, {1'b0, ST_OK, 8'd1, 8'h00}));
    rows.push_back(row(ROW_FEED, 9'h061, 1'b0, 1'b1, {1'b0, ST_OK, 8'd2, 8'h00}));
    rows.push_back(row(ROW_LIMIT, 9'd2));
    rows.push_back(row(ROW_FEED, 9'h062, 1'b0, 1'b1, {1'b0, ST_TOO_LONG, 8'd2, 8'h00}));
    rows.push_back(row(ROW_FEED, CHAR_NUL, 1'b0, 1'b1, {1'b1, ST_TOO_LONG, 8'd2, 8'h00}));
    rows.push_back(row(ROW_LIMIT, 9'd511));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed table
    in_idle  = 1'b1;
    out_idle = 1'b1;
    foreach (rows[r]) begin
      if (rows[r].kind == ROW_LIMIT) begin
        set_limit(rows[r].val);
      end else begin
        beat.opcode     = (rows[r].kind == ROW_READ) ? OP_READ : OP_FEED;
        beat.path_byte  = rows[r].val[7:0];
        beat.last_byte  = rows[r].last;
        beat.read_index = rows[r].val[7:0];
        send_beat(beat, rows[r].typed, rows[r].want);
      end
    end

    // random phases, each with its own limit and idling mix
    while (n_items < ITEMS) begin
      case ($urandom_range(0, 9))
        0:       lim = 9'($urandom_range(0, 3));
        1:       lim = LIMIT_RST;
        2:       lim = 9'($urandom_range(257, 511));
        3, 4:    lim = 9'($urandom_range(4, 24));
        default: lim = 9'($urandom_range(2, 256));
      endcase
      set_limit(lim);
      in_idle  = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(4, 12)) random_path();
    end

    wait_idle();
    repeat (8) @(posedge clk_i);
    $display("checked %0d results from %0d beats: %0d random paths, %0d limit writes",
             n_results, n_items, n_paths, n_cfg);
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side
  // ---------------------------------------------------------------------------

  task automatic cmp_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Take result beats, compare them in order, stall at random
  always @(posedge clk_i) begin : check_results
    apn_out_t want;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        if (pending_res.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, out_data_o);
          errors++;
        end else begin
          want = pending_res.pop_front();
          cmp_field("done_res", 8'(want.done_res), 8'(out_data_o.done_res));
          cmp_field("status", 8'(want.status), 8'(out_data_o.status));
          cmp_field("norm_length", want.norm_length, out_data_o.norm_length);
          cmp_field("read_data", want.read_data, out_data_o.read_data);
          n_results++;
        end
        hold = out_idle ? $urandom_range(0, MAX_GAP) : 0;
      end else if (hold != 0) begin
        hold--;
      end
      out_stall_i <= (hold != 0);
    end
  end

  // Watchdog: give up when no beat moves for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_MAX) begin
      $display("%0t: no beat accepted for %0d cycles", $time, quiet);
      $display("status: fail");
      $finish;
    end
  end

endmodule
